@@ src/mcfir_pkg.sv @@
package mcfir_pkg;

    localparam int COEF_W           = 16;
    localparam int NCOEF            = 8;
    localparam int NCH_FIELDS       = 4;
    localparam int CFG_IDX_W        = 4;
    localparam int FRAC_BITS        = 15;
    localparam int DEF_TAPS         = 8;
    localparam int DEF_CHANNELS     = 4;
    localparam int DEF_SAMPLE_WIDTH = 16;

    localparam logic [COEF_W-1:0] COEF0_RESET = 16'h7fff;
    localparam logic [COEF_W-1:0] COEFN_RESET = 16'h0000;

    // Load strobes for the lane pipeline stages.
    typedef struct packed {
        logic ld_prod;
        logic ld_quad;
        logic ld_sum;
    } t_stage_en;

endpackage

@@ src/mcfir_lane.sv @@
module mcfir_lane #(
    parameter int TAPS         = mcfir_pkg::DEF_TAPS,
    parameter int SAMPLE_WIDTH = mcfir_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  mcfir_pkg::t_stage_en                        i_en,
    input  logic [SAMPLE_WIDTH-1:0]                     i_sample,
    input  logic [TAPS-1:0][mcfir_pkg::COEF_W-1:0]      i_coef,
    output logic [SAMPLE_WIDTH-1:0]                     o_result,
    output logic                                        o_clip
);
    import mcfir_pkg::*;

    localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
    localparam int ACC_W  = PROD_W + 4;
    localparam int RND_W  = ACC_W - FRAC_BITS;
    localparam int NQUAD  = (TAPS + 3) / 4;
    localparam logic [ACC_W-1:0] RND_BIAS =
        {{(ACC_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

    logic [SAMPLE_WIDTH-1:0]   r_hist [TAPS-1];
    logic signed [PROD_W-1:0]  r_prod [TAPS];
    logic signed [ACC_W-1:0]   r_quad [NQUAD];
    logic signed [ACC_W-1:0]   n_quad [NQUAD];
    logic signed [ACC_W-1:0]   w_total;
    logic signed [RND_W-1:0]   w_rnd;
    logic [RND_W-SAMPLE_WIDTH:0] w_top;
    logic                      w_ovf;
    logic [SAMPLE_WIDTH-1:0]   r_result;
    logic                      r_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TAPS - 1; k++) begin
                r_hist[k] <= '0;
            end
        end else if (i_en.ld_prod) begin
            r_hist[0] <= i_sample;
            for (int k = 1; k < TAPS - 1; k++) begin
                r_hist[k] <= r_hist[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ld_prod) begin
            r_prod[0] <= PROD_W'($signed(i_sample)) * PROD_W'($signed(i_coef[0]));
            for (int k = 1; k < TAPS; k++) begin
                r_prod[k] <= PROD_W'($signed(r_hist[k-1])) * PROD_W'($signed(i_coef[k]));
            end
        end
    end

    always_comb begin
        for (int q = 0; q < NQUAD; q++) begin
            n_quad[q] = '0;
            for (int j = 0; j < 4; j++) begin
                if (4 * q + j < TAPS) begin
                    n_quad[q] = n_quad[q] + ACC_W'(r_prod[4*q+j]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ld_quad) begin
            r_quad <= n_quad;
        end
    end

    always_comb begin
        w_total = $signed(RND_BIAS);
        for (int q = 0; q < NQUAD; q++) begin
            w_total = w_total + r_quad[q];
        end
        w_rnd = w_total[ACC_W-1:FRAC_BITS];
        w_top = w_rnd[RND_W-1:SAMPLE_WIDTH-1];
        w_ovf = !((&w_top) || !(|w_top));
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ld_sum) begin
            r_clip <= w_ovf;
            if (!w_ovf) begin
                r_result <= w_rnd[SAMPLE_WIDTH-1:0];
            end else if (w_rnd[RND_W-1]) begin
                r_result <= {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
            end else begin
                r_result <= {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
            end
        end
    end

    assign o_result = r_result;
    assign o_clip   = r_clip;

endmodule

@@ src/mcfir_merge.sv @@
module mcfir_merge #(
    parameter int CHANNELS     = mcfir_pkg::DEF_CHANNELS,
    parameter int SAMPLE_WIDTH = mcfir_pkg::DEF_SAMPLE_WIDTH,
    parameter int OUT_W        = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_ld,
    input  logic [CHANNELS-1:0][SAMPLE_WIDTH-1:0] i_result,
    input  logic [CHANNELS-1:0]                  i_clip,
    output logic [OUT_W-1:0]                     o_tdata,
    output logic                                 o_clip
);
    import mcfir_pkg::*;

    logic [OUT_W-1:0] n_tdata;
    logic [OUT_W-1:0] r_tdata;
    logic             r_clip;

    always_comb begin
        n_tdata = '0;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            n_tdata[ch*SAMPLE_WIDTH +: SAMPLE_WIDTH] = i_result[ch];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_tdata <= n_tdata;
            r_clip  <= |i_clip;
        end
    end

    assign o_tdata = r_tdata;
    assign o_clip  = r_clip;

endmodule

@@ src/multichannel_fir_filter_unit.sv @@
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata: sample_ch0..sample_ch3
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: filtered_ch0..3, tuser: clipped
// cfg       in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data (coef_0..7)
//
// One beat is accepted per cycle while s_axis_tready is high; a result then passes through
// the partial sum, final sum and output registers before m_axis_tvalid rises.
// The four stages are product, partial sum, final sum with rounding, and output register.
// Each stage moves on when the stage after it is empty or moving, so a stall on m_axis
// only fills the pipeline; s_axis_tready drops once all four stages hold data.
// Reset clears the sample history and the stage valid bits, loads coef_0 = 0x7fff and clears coef_1..7.
// The configuration port is always ready.
module multichannel_fir_filter_unit #(
    parameter int TAPS         = mcfir_pkg::DEF_TAPS,
    parameter int CHANNELS     = mcfir_pkg::DEF_CHANNELS,
    parameter int SAMPLE_WIDTH = mcfir_pkg::DEF_SAMPLE_WIDTH,
    localparam int DATA_W =
        ((mcfir_pkg::NCH_FIELDS * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // sample_ch0, sample_ch1, sample_ch2, sample_ch3, zero fill
    input  logic [DATA_W-1:0]                   s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // filtered_ch0, filtered_ch1, filtered_ch2, filtered_ch3, zero fill
    output logic [DATA_W-1:0]                   m_axis_tdata,
    // clipped
    output logic [0:0]                          m_axis_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mcfir_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mcfir_pkg::COEF_W-1:0]        i_cfg_data
);
    import mcfir_pkg::*;

    logic [COEF_W-1:0]                  r_coef [NCOEF];
    logic [TAPS-1:0][COEF_W-1:0]        w_coef;
    logic                               r_v1, r_v2, r_v3, r_v4;
    logic                               w_rdy1, w_rdy2, w_rdy3, w_rdy4;
    logic                               w_ld4;
    t_stage_en                          w_en;
    logic [CHANNELS-1:0][SAMPLE_WIDTH-1:0] w_result;
    logic [CHANNELS-1:0]                w_clip;
    logic                               w_mclip;
    logic                               w_at_rail;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[0] <= COEF0_RESET;
            for (int k = 1; k < NCOEF; k++) begin
                r_coef[k] <= COEFN_RESET;
            end
        end else if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(NCOEF))) begin
            r_coef[i_cfg_index[$clog2(NCOEF)-1:0]] <= i_cfg_data;
        end
    end

    always_comb begin
        for (int k = 0; k < TAPS; k++) begin
            w_coef[k] = r_coef[k];
        end
    end

    assign w_rdy4 = !r_v4 || m_axis_tready;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    assign s_axis_tready = w_rdy1;
    assign w_en.ld_prod  = s_axis_tvalid && w_rdy1;
    assign w_en.ld_quad  = r_v1 && w_rdy2;
    assign w_en.ld_sum   = r_v2 && w_rdy3;
    assign w_ld4         = r_v3 && w_rdy4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= s_axis_tvalid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
        mcfir_lane #(
            .TAPS         (TAPS),
            .SAMPLE_WIDTH (SAMPLE_WIDTH)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_sample (s_axis_tdata[ch*SAMPLE_WIDTH +: SAMPLE_WIDTH]),
            .i_coef   (w_coef),
            .o_result (w_result[ch]),
            .o_clip   (w_clip[ch])
        );
    end

    mcfir_merge #(
        .CHANNELS     (CHANNELS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .OUT_W        (DATA_W)
    ) u_merge (
        .i_clk    (i_clk),
        .i_ld     (w_ld4),
        .i_result (w_result),
        .i_clip   (w_clip),
        .o_tdata  (m_axis_tdata),
        .o_clip   (w_mclip)
    );

    assign m_axis_tvalid   = r_v4;
    assign m_axis_tuser[0] = w_mclip;

    always_comb begin
        w_at_rail = 1'b0;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            if ((m_axis_tdata[ch*SAMPLE_WIDTH +: SAMPLE_WIDTH]
                    == {1'b1, {(SAMPLE_WIDTH-1){1'b0}}})
                || (m_axis_tdata[ch*SAMPLE_WIDTH +: SAMPLE_WIDTH]
                    == {1'b0, {(SAMPLE_WIDTH-1){1'b1}}})) begin
                w_at_rail = 1'b1;
            end
        end
    end

    a_accept_fills_stage1 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_v1)
        else $error("accepted beat did not enter the first stage");

    a_full_blocks_input : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && r_v4 && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while the pipeline is full and stalled");

    a_stalled_stage_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_v4 && !m_axis_tready) |=> (r_v3 && r_v4))
        else $error("pipeline stage dropped a beat during a stall");

    a_clip_at_rail : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> w_at_rail)
        else $error("clipped flag set without a saturated channel");

endmodule

@@ tb/multichannel_fir_filter_unit_tb.sv @@
`timescale 1ns / 1ps

module multichannel_fir_filter_unit_tb;

    localparam int SW          = mcfir_pkg::DEF_SAMPLE_WIDTH;
    localparam int NCH         = mcfir_pkg::DEF_CHANNELS;
    localparam int NTAP        = mcfir_pkg::DEF_TAPS;
    localparam int DATA_W      = ((mcfir_pkg::NCH_FIELDS * SW + 7) / 8) * 8;
    localparam int IDX_MAX     = (1 << mcfir_pkg::CFG_IDX_W) - 1;
    localparam int STALL_LIMIT = 5000;
    localparam int PRINT_LIMIT = 40;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_BEATS = 106;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_ITEM,
        ROW_ITEM_CHK
    } t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        logic [3:0]         cfg_idx;
        logic [15:0]        cfg_val;
        logic [DATA_W-1:0]  smp;
        logic [DATA_W-1:0]  want;
        logic               want_clip;
    } t_stim_row;

    typedef struct packed {
        logic [DATA_W-1:0]  data;
        logic               clip;
    } t_fir_result;

    // Samples and results are packed as {ch3, ch2, ch1, ch0}.
    localparam int NUM_ROWS = 31;
    localparam t_stim_row DIRECTED [NUM_ROWS] = '{
        '{ROW_ITEM_CHK, 4'd0,  16'h0000, 64'h0001_0000_8000_7fff, 64'h0001_0000_8001_7ffe, 1'b0},
        '{ROW_ITEM_CHK, 4'd0,  16'h0000, 64'h0002_c000_4000_ffff, 64'h0002_c001_4000_ffff, 1'b0},
        '{ROW_CFG,      4'd0,  16'h8000, 64'h0, 64'h0, 1'b0},
        '{ROW_ITEM_CHK, 4'd0,  16'h0000, 64'h0001_0000_7fff_8000, 64'hffff_0000_8001_7fff, 1'b1},
        '{ROW_CFG,      4'd8,  16'h1234, 64'h0, 64'h0, 1'b0},
        '{ROW_CFG,      4'd15, 16'h7fff, 64'h0, 64'h0, 1'b0},
        '{ROW_ITEM_CHK, 4'd0,  16'h0000, 64'h0000_0000_ff9c_0064, 64'h0000_0000_0064_ff9c, 1'b0},
        '{ROW_CFG,      4'd0,  16'h7fff, 64'h0, 64'h0, 1'b0},
        '{ROW_CFG,      4'd1,  16'h7fff, 64'h0, 64'h0, 1'b0},
        '{ROW_CFG,      4'd2,  16'h7fff, 64'h0, 64'h0, 1'b0},
        '{ROW_CFG,      4'd3,  16'h7fff, 64'h0, 64'h0, 1'b0},
        '{ROW_CFG,      4'd4,  16'h7fff, 64'h0, 64'h0, 1'b0},
        '{ROW_CFG,      4'd5,  16'h7fff, 64'h0, 64'h0, 1'b0},
        '{ROW_CFG,      4'd6,  16'h7fff, 64'h0, 64'h0, 1'b0},
        '{ROW_CFG,      4'd7,  16'h7fff, 64'h0, 64'h0, 1'b0},
        '{ROW_ITEM,     4'd0,  16'h0000, 64'h7fff_7fff_7fff_7fff, 64'h0, 1'b0},
        '{ROW_ITEM,     4'd0,  16'h0000, 64'h8000_8000_8000_8000, 64'h0, 1'b0},
        '{ROW_ITEM,     4'd0,  16'h0000, 64'h7fff_8000_0001_ffff, 64'h0, 1'b0},
        '{ROW_ITEM,     4'd0,  16'h0000, 64'h0000_7fff_8000_0000, 64'h0, 1'b0},
        '{ROW_CFG,      4'd0,  16'h8000, 64'h0, 64'h0, 1'b0},
        '{ROW_CFG,      4'd1,  16'h8000, 64'h0, 64'h0, 1'b0},
        '{ROW_CFG,      4'd2,  16'h8000, 64'h0, 64'h0, 1'b0},
        '{ROW_CFG,      4'd3,  16'h8000, 64'h0, 64'h0, 1'b0},
        '{ROW_CFG,      4'd4,  16'h8000, 64'h0, 64'h0, 1'b0},
        '{ROW_CFG,      4'd5,  16'h8000, 64'h0, 64'h0, 1'b0},
        '{ROW_CFG,      4'd6,  16'h8000, 64'h0, 64'h0, 1'b0},
        '{ROW_CFG,      4'd7,  16'h8000, 64'h0, 64'h0, 1'b0},
        '{ROW_ITEM,     4'd0,  16'h0000, 64'h8000_8000_8000_8000, 64'h0, 1'b0},
        '{ROW_ITEM,     4'd0,  16'h0000, 64'h8000_8000_8000_8000, 64'h0, 1'b0},
        '{ROW_ITEM,     4'd0,  16'h0000, 64'h7fff_0000_8000_1234, 64'h0, 1'b0},
        '{ROW_ITEM,     4'd0,  16'h0000, 64'hffff_0001_ffff_0001, 64'h0, 1'b0}
    };

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [DATA_W-1:0]                  s_axis_tdata = '0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [DATA_W-1:0]                  m_axis_tdata;
    logic [0:0]                         m_axis_tuser;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [mcfir_pkg::CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [mcfir_pkg::COEF_W-1:0]       i_cfg_data = '0;

    logic signed [SW-1:0]               tap_hist [NTAP][NCH];
    logic signed [15:0]                 tap_coef [mcfir_pkg::NCOEF];
    logic [2:0]                         fir_slot;
    t_fir_result                        filt_expect [$];
    t_fir_result                        typed_res;
    t_fir_result                        want;
    logic                               typed_valid = 1'b0;

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int mismatches = 0;
    int beats_in = 0;
    int results_out = 0;
    int clipped_seen = 0;
    int cfg_writes = 0;
    int quiet_cycles = 0;

    multichannel_fir_filter_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    // Writes the new samples into the history, forms every channel's tap sum, rounds
    // half up and saturates, then advances the write slot.
    function automatic t_fir_result fir_predict(input logic [DATA_W-1:0] beat);
        t_fir_result res;
        longint acc;
        longint rnd;
        logic [2:0] idx;
        res = '0;
        for (int ch = 0; ch < NCH; ch++) begin
            tap_hist[fir_slot][ch] = beat[SW*ch +: SW];
        end
        for (int ch = 0; ch < NCH; ch++) begin
            acc = 0;
            for (int k = 0; k < NTAP; k++) begin
                idx = fir_slot - 3'(k);
                acc += longint'(tap_hist[idx][ch]) * longint'(tap_coef[k]);
            end
            rnd = (acc + 64'sd16384) >>> mcfir_pkg::FRAC_BITS;
            if (rnd > 32767) begin
                rnd = 32767;
                res.clip = 1'b1;
            end else if (rnd < -32768) begin
                rnd = -32768;
                res.clip = 1'b1;
            end
            res.data[SW*ch +: SW] = rnd[SW-1:0];
        end
        fir_slot = (fir_slot == 3'(NTAP - 1)) ? 3'd0 : fir_slot + 3'd1;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index < mcfir_pkg::NCOEF) begin
                    tap_coef[i_cfg_index[2:0]] = i_cfg_data;
                end
                cfg_writes++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                want = fir_predict(s_axis_tdata);
                if (typed_valid) begin
                    want = typed_res;
                end
                filt_expect.push_back(want);
                beats_in++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (filt_expect.size() == 0) begin
                    report_mismatch($sformatf("unexpected result beat, tdata %h", m_axis_tdata));
                end else begin
                    want = filt_expect.pop_front();
                    for (int ch = 0; ch < mcfir_pkg::NCH_FIELDS; ch++) begin
                        if (m_axis_tdata[SW*ch +: SW] !== want.data[SW*ch +: SW]) begin
                            report_mismatch($sformatf("result %0d filtered_ch%0d: got %0d, expected %0d",
                                results_out, ch, $signed(m_axis_tdata[SW*ch +: SW]),
                                $signed(want.data[SW*ch +: SW])));
                        end
                    end
                    if (m_axis_tuser[0] !== want.clip) begin
                        report_mismatch($sformatf("result %0d clipped: got %b, expected %b",
                            results_out, m_axis_tuser[0], want.clip));
                    end
                    if (want.clip) begin
                        clipped_seen++;
                    end
                end
                results_out++;
            end
            if ((i_cfg_valid && o_cfg_ready) || (s_axis_tvalid && s_axis_tready)
                    || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic send_samples(input logic [DATA_W-1:0] beat, input logic chk,
                                input t_fir_result chk_res);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        typed_valid = chk;
        typed_res = chk_res;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= beat;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic write_coef(input logic [3:0] idx, input logic [15:0] val);
        s_axis_tvalid <= 1'b0;
        while (filt_expect.size() != 0) begin
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        logic [DATA_W-1:0] beat;
        logic [15:0] cval;
        int mode;

        for (int t = 0; t < NTAP; t++) begin
            for (int ch = 0; ch < NCH; ch++) begin
                tap_hist[t][ch] = '0;
            end
        end
        tap_coef[0] = mcfir_pkg::COEF0_RESET;
        for (int k = 1; k < mcfir_pkg::NCOEF; k++) begin
            tap_coef[k] = mcfir_pkg::COEFN_RESET;
        end
        fir_slot = '0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < NUM_ROWS; r++) begin
            if (DIRECTED[r].kind == ROW_CFG) begin
                write_coef(DIRECTED[r].cfg_idx, DIRECTED[r].cfg_val);
            end else begin
                send_samples(DIRECTED[r].smp, DIRECTED[r].kind == ROW_ITEM_CHK,
                             {DIRECTED[r].want, DIRECTED[r].want_clip});
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            mode = phase % 4;
            for (int k = 0; k < mcfir_pkg::NCOEF; k++) begin
                case (mode)
                    0: cval = 16'($urandom);
                    1: cval = 16'h7fff;
                    2: cval = 16'h8000;
                    default: cval = 16'($urandom_range(0, 8191) - 4096);
                endcase
                write_coef(4'(k), cval);
            end
            write_coef(4'($urandom_range(mcfir_pkg::NCOEF, IDX_MAX)), 16'($urandom));

            case ((phase / 2) % 4)
                0: begin
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct = 81;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct = 0;
                    sink_stall_pct = 81;
                end
                default: begin
                    src_idle_pct = 23;
                    sink_stall_pct = 23;
                end
            endcase

            for (int n = 0; n < PHASE_BEATS; n++) begin
                for (int ch = 0; ch < mcfir_pkg::NCH_FIELDS; ch++) begin
                    case ($urandom_range(0, 7))
                        0: beat[SW*ch +: SW] = 16'h7fff;
                        1: beat[SW*ch +: SW] = 16'h8000;
                        2: beat[SW*ch +: SW] = '0;
                        default: beat[SW*ch +: SW] = SW'($urandom);
                    endcase
                end
                send_samples(beat, 1'b0, '0);
            end
            s_axis_tvalid <= 1'b0;
            src_idle_pct = 0;
            sink_stall_pct = 0;
        end

        while (filt_expect.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (12) @(negedge i_clk);

        $display("Sent %0d sample beats and checked %0d results (%0d clipped).",
                 beats_in, results_out, clipped_seen);
        $display("Made %0d coefficient writes across %0d phases; %0d mismatches.",
                 cfg_writes, NUM_PHASES, mismatches);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
